@@ hw/rtl/tssm_pkg.sv @@
// Shared types and codes for the two-stacks shared memory unit.
package tssm_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 9;

    typedef logic [1:0]        func_t;
    typedef logic [1:0]        status_t;
    typedef logic [CAP_W-1:0]  cap_t;
    typedef logic [DATA_W-1:0] word_t;

    localparam func_t FUNC_PUSH = 2'd0;
    localparam func_t FUNC_POP  = 2'd1;
    localparam func_t FUNC_PEEK = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam cap_t CAP_RESET = 9'd256;

endpackage

@@ hw/rtl/two_stacks_shared_memory_unit.sv @@
// Two stacks in one shared memory: lower grows up from 0, upper grows down from capacity.
//
//  channel   signals                                           dir  transaction when
//  command   start, busy, func, stack_select, push_value       in   start && !busy
//  result    done, status, read_value                          out  done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_data                    in   cfg_valid && cfg_ready
//
// One command per cycle while busy is low; its result shows in the cycle after the command is taken.
// Push writes and peek reads the single memory port in the command's cycle; the
// registered read data returns with the result, so back-to-back push/peek never overlap.
// busy is high while a capacity write is offered; that write clears both stacks.
// Reset empties both stacks and sets capacity to 256; memory contents are not cleared.
module two_stacks_shared_memory_unit #(
    parameter int DEPTH = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tssm_pkg::func_t        func,
    input  logic                   stack_select,
    input  logic signed [31:0]     push_value,
    output logic                   done,
    output tssm_pkg::status_t      status,
    output logic signed [31:0]     read_value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  tssm_pkg::cap_t         cfg_data
);
    import tssm_pkg::*;

    localparam int   AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam cap_t CAP_MAX = CAP_W'((DEPTH > 511) ? 511 : DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    word_t             mem_q_reg;

    cap_t    capacity_reg, capacity_next;
    cap_t    lower_count_reg, lower_count_next;
    cap_t    upper_count_reg, upper_count_next;
    logic    done_reg;
    status_t status_reg, status_next;
    word_t   value_reg, value_next;
    logic    rd_mem_reg, rd_mem_next;

    cap_t          cap;
    logic [CAP_W:0] used;
    logic          full;
    logic          in_accept;
    logic          mem_we;
    logic          mem_re;
    cap_t          addr9;
    logic [AW-1:0] mem_addr;

    assign cap       = (capacity_reg > CAP_MAX) ? CAP_MAX : capacity_reg;
    assign used      = {1'b0, lower_count_reg} + {1'b0, upper_count_reg};
    assign full      = used >= {1'b0, cap};
    assign busy      = cfg_valid;
    assign cfg_ready = 1'b1;
    assign in_accept = start && !busy;
    assign mem_addr  = AW'(addr9);

    always_comb
    begin
        capacity_next    = capacity_reg;
        lower_count_next = lower_count_reg;
        upper_count_next = upper_count_reg;
        status_next      = ST_OK;
        value_next       = '0;
        rd_mem_next      = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        addr9            = lower_count_reg;
        if (cfg_valid)
        begin
            capacity_next    = cfg_data;
            lower_count_next = '0;
            upper_count_next = '0;
        end
        else if (start)
        begin
            case (func)
                FUNC_PUSH:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else if (!stack_select)
                    begin
                        addr9            = lower_count_reg;
                        mem_we           = 1'b1;
                        lower_count_next = lower_count_reg + 1'b1;
                    end
                    else
                    begin
                        addr9            = cap - upper_count_reg - 1'b1;
                        mem_we           = 1'b1;
                        upper_count_next = upper_count_reg + 1'b1;
                    end
                end
                FUNC_POP:
                begin
                    if (!stack_select)
                    begin
                        if (lower_count_reg == '0)
                            status_next = ST_EMPTY;
                        else
                            lower_count_next = lower_count_reg - 1'b1;
                    end
                    else
                    begin
                        if (upper_count_reg == '0)
                            status_next = ST_EMPTY;
                        else
                            upper_count_next = upper_count_reg - 1'b1;
                    end
                end
                FUNC_PEEK:
                begin
                    if (!stack_select)
                    begin
                        if (lower_count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            value_next  = '1;
                        end
                        else
                        begin
                            addr9       = lower_count_reg - 1'b1;
                            mem_re      = 1'b1;
                            rd_mem_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (upper_count_reg == '0 || upper_count_reg > cap)
                        begin
                            status_next = ST_EMPTY;
                            value_next  = '1;
                        end
                        else
                        begin
                            addr9       = cap - upper_count_reg;
                            mem_re      = 1'b1;
                            rd_mem_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= push_value;
        if (mem_re)
            mem_q_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= CAP_RESET;
            lower_count_reg <= '0;
            upper_count_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            capacity_reg    <= capacity_next;
            lower_count_reg <= lower_count_next;
            upper_count_reg <= upper_count_next;
            done_reg        <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            rd_mem_reg <= rd_mem_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = rd_mem_reg ? mem_q_reg : value_reg;

    // stacks never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        used <= {1'b0, cap})
        else $error("stack counts exceed capacity");

    // exactly one result per transaction, in the cycle after it
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> done)
        else $error("missing result strobe");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_accept))
        else $error("result strobe without transaction");

    // refused push leaves both stacks unchanged
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && func == FUNC_PUSH && full) |=>
            ($stable(lower_count_reg) && $stable(upper_count_reg)))
        else $error("refused push changed a stack");

endmodule
